>>> design/olist_pkg.sv
`default_nettype none

package olist_pkg;

  // fixed field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned RPOS_W   = 4;
  localparam int unsigned CNT_W    = 5;

  // default list depth
  localparam int unsigned CAPACITY = 16;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND  = 3'd0,
    KIND_INSERT  = 3'd1,
    KIND_FIND    = 3'd2,
    KIND_READ    = 3'd3,
    KIND_DEL_VAL = 3'd4,
    KIND_DEL_POS = 3'd5
  } olist_kind_e;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } olist_state_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;        // open a slot at pos and write the new value
    logic del;        // close a slot, entries above move down
    logic by_match;   // delete slot is the first match instead of pos
  } olist_op_t;

endpackage

`default_nettype wire

>>> design/olist_cell.sv
`default_nettype none

module olist_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned XW  = 5
) (
  input  wire logic                         clk_i,
  input  wire logic                         cmp_en_i,
  input  wire logic [olist_pkg::DATA_W-1:0] cmp_value_i,
  input  wire logic [XW-1:0]                count_i,
  input  wire olist_pkg::olist_op_t         op_i,
  input  wire logic [XW-1:0]                pos_i,
  input  wire logic [olist_pkg::DATA_W-1:0] ins_value_i,
  input  wire logic [olist_pkg::DATA_W-1:0] prev_entry_i,
  input  wire logic [olist_pkg::DATA_W-1:0] next_entry_i,
  input  wire logic                         seen_i,
  output logic                              seen_o,
  output logic                              first_o,
  output logic [olist_pkg::DATA_W-1:0]      entry_o,
  output logic [olist_pkg::DATA_W-1:0]      rd_o
);

  localparam logic [XW-1:0] MyIdx = XW'(IDX);

  logic [olist_pkg::DATA_W-1:0] entry_q, entry_d;
  logic                         match_q;
  logic                         occupied;
  logic                         at_pos;
  logic                         above_pos;
  logic                         shift_down;

  assign occupied  = MyIdx < count_i;
  assign at_pos    = MyIdx == pos_i;
  assign above_pos = MyIdx > pos_i;

  // match chain: seen_o is set once any cell at or below this one matched
  assign seen_o  = seen_i | match_q;
  assign first_o = match_q & ~seen_i;

  assign shift_down = op_i.by_match ? seen_o : (at_pos | above_pos);

  // next entry: take the lower neighbor on insert, the upper on delete
  always_comb begin
    entry_d = entry_q;
    if (op_i.ins) begin
      if (at_pos) begin
        entry_d = ins_value_i;
      end else if (above_pos) begin
        entry_d = prev_entry_i;
      end
    end else if (op_i.del && shift_down) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // compare against the incoming word while the list is at rest
  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      match_q <= occupied && (entry_q == cmp_value_i);
    end
  end

  assign entry_o = entry_q;
  assign rd_o    = at_pos ? entry_q : '0;

endmodule

`default_nettype wire

>>> design/ordered_list_engine_unit.sv
`default_nettype none

// Ordered list of signed 32-bit values, at most CAPACITY entries, kept packed
// from position 0 upward in a row of cells.
// Request channel: kind_i, item_value_i and position_i are taken at a rising
// edge where start_i is high and busy_o is low. On that edge every cell
// compares its entry with item_value_i and registers the match.
// The next cycle (busy_o high) resolves the first match along the cell chain,
// moves entries up or down by one cell and updates the count.
// Result channel: valid_o is high for exactly one cycle, the cycle right after
// the busy cycle, with ok_o, result_position_o, result_value_o and entry_count_o.
// The receiver cannot stall; a result not taken in that cycle is gone.
// A new request is not taken while busy_o is high; the busy cycle holds the
// priority chain across all cells plus the shift.
// A new request may be accepted in the same cycle a result is shown.
// Reset clears the count and the strobe; entry storage is not cleared and
// positions at or above the count are never read.
module ordered_list_engine_unit #(
  parameter int unsigned CAPACITY = olist_pkg::CAPACITY
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [olist_pkg::KIND_W-1:0]        kind_i,
  input  wire logic signed [olist_pkg::DATA_W-1:0] item_value_i,
  input  wire logic [olist_pkg::POS_W-1:0]         position_i,
  output logic                                     valid_o,
  output logic                                     ok_o,
  output logic [olist_pkg::RPOS_W-1:0]             result_position_o,
  output logic signed [olist_pkg::DATA_W-1:0]      result_value_o,
  output logic [olist_pkg::CNT_W-1:0]              entry_count_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned XW = (CW > olist_pkg::POS_W) ? CW : olist_pkg::POS_W;
  localparam logic [CW-1:0] CapLimit = CW'(CAPACITY);

  olist_pkg::olist_state_e state_q, state_d;
  olist_pkg::olist_kind_e  kind_q;
  logic [olist_pkg::DATA_W-1:0] value_q;
  logic [XW-1:0]           pos_q;
  logic [CW-1:0]           count_q, count_d;
  logic [XW-1:0]           count_x;

  logic accept;
  logic apply;

  logic                         valid_q;
  logic                         ok_q;
  logic [olist_pkg::RPOS_W-1:0] rpos_q;
  logic [olist_pkg::DATA_W-1:0] rval_q;

  // cell chain wiring
  logic [olist_pkg::DATA_W-1:0] entry [CAPACITY];
  logic [olist_pkg::DATA_W-1:0] rd    [CAPACITY];
  logic [CAPACITY:0]            seen;
  logic [CAPACITY-1:0]          first;
  olist_pkg::olist_op_t         op;

  logic                         found;
  logic [IW-1:0]                match_pos;
  logic [olist_pkg::DATA_W-1:0] rd_word;
  logic                         ins_ok;
  logic                         pos_in_range;
  logic                         ok_d;
  logic [XW-1:0]                rpos_x;
  logic [olist_pkg::DATA_W-1:0] rval_d;

  assign count_x = XW'(count_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      olist_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = olist_pkg::ST_APPLY;
        end
      end
      olist_pkg::ST_APPLY: state_d = olist_pkg::ST_IDLE;
      default:             state_d = olist_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy_o = 1'b0;
    apply  = 1'b0;
    case (state_q)
      olist_pkg::ST_IDLE:  busy_o = 1'b0;
      olist_pkg::ST_APPLY: begin
        busy_o = 1'b1;
        apply  = 1'b1;
      end
      default:             busy_o = 1'b0;
    endcase
  end

  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olist_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture; append targets the current end of the list
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= olist_pkg::olist_kind_e'(kind_i);
      value_q <= item_value_i;
      if (olist_pkg::olist_kind_e'(kind_i) == olist_pkg::KIND_APPEND) begin
        pos_q <= count_x;
      end else begin
        pos_q <= XW'(position_i);
      end
    end
  end

  // row of cells
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [olist_pkg::DATA_W-1:0] prev_w;
    logic [olist_pkg::DATA_W-1:0] next_w;

    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_lo
      assign prev_w = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_hi
      assign next_w = entry[i+1];
    end

    olist_cell #(
      .IDX (i),
      .XW  (XW)
    ) u_cell (
      .clk_i        (clk_i),
      .cmp_en_i     (accept),
      .cmp_value_i  (item_value_i),
      .count_i      (count_x),
      .op_i         (op),
      .pos_i        (pos_q),
      .ins_value_i  (value_q),
      .prev_entry_i (prev_w),
      .next_entry_i (next_w),
      .seen_i       (seen[i]),
      .seen_o       (seen[i+1]),
      .first_o      (first[i]),
      .entry_o      (entry[i]),
      .rd_o         (rd[i])
    );
  end

  assign found = seen[CAPACITY];

  // first match position and read word, both from one-hot cell outputs
  always_comb begin
    match_pos = '0;
    rd_word   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        match_pos = match_pos | IW'(i);
      end
      rd_word = rd_word | rd[i];
    end
  end

  assign ins_ok       = (count_q < CapLimit) && (pos_q <= count_x);
  assign pos_in_range = pos_q < count_x;

  // decide the request outcome during the apply cycle
  always_comb begin
    op       = '0;
    ok_d     = 1'b0;
    rpos_x   = '0;
    rval_d   = '0;
    count_d  = count_q;
    case (kind_q)
      olist_pkg::KIND_APPEND, olist_pkg::KIND_INSERT: begin
        if (ins_ok) begin
          ok_d    = 1'b1;
          rpos_x  = pos_q;
          op.ins  = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      olist_pkg::KIND_FIND: begin
        if (found) begin
          ok_d   = 1'b1;
          rpos_x = XW'(match_pos);
        end
      end
      olist_pkg::KIND_READ: begin
        if (pos_in_range) begin
          ok_d   = 1'b1;
          rpos_x = pos_q;
          rval_d = rd_word;
        end
      end
      olist_pkg::KIND_DEL_VAL: begin
        if (found) begin
          ok_d        = 1'b1;
          rpos_x      = XW'(match_pos);
          op.del      = 1'b1;
          op.by_match = 1'b1;
          count_d     = count_q - CW'(1);
        end
      end
      olist_pkg::KIND_DEL_POS: begin
        if (pos_in_range) begin
          ok_d    = 1'b1;
          rpos_x  = pos_q;
          op.del  = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      default: ok_d = 1'b0;
    endcase
    if (!apply) begin
      op      = '0;
      count_d = count_q;
    end
  end

  // count and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= apply;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (apply) begin
      ok_q   <= ok_d;
      rpos_q <= rpos_x[olist_pkg::RPOS_W-1:0];
      rval_q <= rval_d;
    end
  end

  assign valid_o           = valid_q;
  assign ok_o              = ok_q;
  assign result_position_o = rpos_q;
  assign result_value_o    = rval_q;
  assign entry_count_o     = count_x[olist_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

>>> design/olist_checker.sv
`default_nettype none

module olist_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                start_i,
  input wire logic                                busy_o,
  input wire logic                                valid_o,
  input wire logic                                ok_o,
  input wire logic [olist_pkg::RPOS_W-1:0]        result_position_o,
  input wire logic signed [olist_pkg::DATA_W-1:0] result_value_o
);

  // an accepted word keeps the unit busy for the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted word did not raise busy");

  // busy is followed by an idle cycle carrying the result strobe
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o && valid_o)
    else $error("busy cycle not followed by result strobe");

  // a strobe only follows a busy cycle
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result strobe without prior work");

  // a failed request reports zero position and value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ok_o |-> result_position_o == '0 && result_value_o == '0)
    else $error("failed request reports nonzero fields");

endmodule

bind ordered_list_engine_unit olist_checker u_olist_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .valid_o           (valid_o),
  .ok_o              (ok_o),
  .result_position_o (result_position_o),
  .result_value_o    (result_value_o)
);

`default_nettype wire
